[rtl/lfr_pkg.sv]
// ---------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the LRU frame replacer.
// ---------------------------------------------------------------------------
package lfr_pkg;

	localparam int FRAME_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int FRAME_SPAN = 64;
	localparam int NUM_FRAMES_DEF = 64;

	typedef enum logic [1:0] {
		ACT_VICTIM = 2'd0,
		ACT_PIN    = 2'd1,
		ACT_UNPIN  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef struct packed {
		logic start;
		logic exec;
	} lfr_cmd_t;

endpackage

[rtl/lfr_if.sv]
// ---------------------------------------------------------------------------
// lfr_if
// Request and response channels of the LRU frame replacer.
// ---------------------------------------------------------------------------
interface lfr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [5:0] frame;

	modport source(output valid, action, frame, input ready);
	modport sink(input valid, action, frame, output ready);
endinterface

interface lfr_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [5:0] victim_frame;
	logic [6:0] count;

	modport source(output valid, found, victim_frame, count, input ready);
	modport sink(input valid, found, victim_frame, count, output ready);
endinterface

[rtl/lfr_ram.sv]
// ---------------------------------------------------------------------------
// lfr_ram
// Generic single write port RAM with registered read.
// ---------------------------------------------------------------------------
module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/lfr_ctrl.sv]
// ---------------------------------------------------------------------------
// lfr_ctrl
// Request sequencer: accept, execute, hold result word until taken.
// ---------------------------------------------------------------------------
module lfr_ctrl
	import lfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output lfr_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign cmd.start = req_valid && req_ready;
	assign cmd.exec  = (state_q == ST_EXEC);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/lfr_dpath.sv]
// ---------------------------------------------------------------------------
// lfr_dpath
// Member bits, end pointers, count and the two link RAMs of the recency list.
// ---------------------------------------------------------------------------
module lfr_dpath
	import lfr_pkg::*;
#(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lfr_cmd_t           cmd,
	input  logic [1:0]         action,
	input  logic [FRAME_W-1:0] frame,
	output logic               found,
	output logic [FRAME_W-1:0] victim_frame,
	output logic [COUNT_W-1:0] count
);

	localparam int DEPTH = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [FRAME_W:0] LIMIT = (FRAME_W + 1)'(DEPTH);

	logic [DEPTH-1:0]   member_q;
	logic [IDX_W-1:0]   newest_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [COUNT_W-1:0] count_q;
	logic               found_q;
	logic [FRAME_W-1:0] vf_q;

	action_t            act_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               in_range_s1;

	logic [IDX_W+FRAME_W-1:0] frame_ext;
	logic [IDX_W-1:0]         frame_idx;
	logic [IDX_W-1:0]         rd_addr;
	logic [IDX_W-1:0]         older_rd;
	logic [IDX_W-1:0]         newer_rd;
	logic [IDX_W+FRAME_W-1:0] oldest_ext;

	logic             older_we;
	logic [IDX_W-1:0] older_waddr;
	logic [IDX_W-1:0] older_wdata;
	logic             newer_we;
	logic [IDX_W-1:0] newer_waddr;
	logic [IDX_W-1:0] newer_wdata;

	logic             do_drop;
	logic             do_add;
	logic [IDX_W-1:0] drop_idx;

	assign frame_ext  = {{IDX_W{1'b0}}, frame};
	assign frame_idx  = frame_ext[IDX_W-1:0];
	assign rd_addr    = (action_t'(action) == ACT_VICTIM) ? oldest_q : frame_idx;
	assign oldest_ext = {{FRAME_W{1'b0}}, oldest_q};

	always_comb begin
		do_drop  = 1'b0;
		do_add   = 1'b0;
		drop_idx = idx_s1;
		unique case (act_s1)
			ACT_VICTIM: begin
				do_drop  = (count_q != '0);
				drop_idx = oldest_q;
			end
			ACT_PIN:   do_drop = in_range_s1 && member_q[idx_s1];
			ACT_UNPIN: do_add  = in_range_s1 && !member_q[idx_s1];
			ACT_NOP:   ;
			default:   ;
		endcase
	end

	// link write-back: unlink on drop, append on add
	always_comb begin
		older_we    = 1'b0;
		older_waddr = newer_rd;
		older_wdata = older_rd;
		newer_we    = 1'b0;
		newer_waddr = older_rd;
		newer_wdata = newer_rd;
		if (cmd.exec && do_drop && (count_q > COUNT_W'(1))) begin
			older_we = (drop_idx != newest_q);
			newer_we = (drop_idx != oldest_q);
		end else if (cmd.exec && do_add && (count_q != '0)) begin
			newer_we    = 1'b1;
			newer_waddr = newest_q;
			newer_wdata = idx_s1;
			older_we    = 1'b1;
			older_waddr = idx_s1;
			older_wdata = newest_q;
		end
	end

	lfr_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_older_ram (
		.clk   (clk),
		.we    (older_we),
		.waddr (older_waddr),
		.wdata (older_wdata),
		.re    (cmd.start),
		.raddr (rd_addr),
		.rdata (older_rd)
	);

	lfr_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_newer_ram (
		.clk   (clk),
		.we    (newer_we),
		.waddr (newer_waddr),
		.wdata (newer_wdata),
		.re    (cmd.start),
		.raddr (rd_addr),
		.rdata (newer_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_s1      <= action_t'(action);
			idx_s1      <= frame_idx;
			in_range_s1 <= ({1'b0, frame} < LIMIT);
		end
		if (cmd.exec) begin
			found_q <= (act_s1 == ACT_VICTIM) && do_drop;
			vf_q    <= ((act_s1 == ACT_VICTIM) && do_drop) ?
				oldest_ext[FRAME_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
			newest_q <= '0;
			oldest_q <= '0;
			count_q  <= '0;
		end else if (cmd.exec) begin
			if (do_drop) begin
				member_q[drop_idx] <= 1'b0;
				if (count_q <= COUNT_W'(1)) begin
					newest_q <= '0;
					oldest_q <= '0;
					count_q  <= '0;
				end else begin
					if (drop_idx == newest_q) begin
						newest_q <= older_rd;
					end
					if (drop_idx == oldest_q) begin
						oldest_q <= newer_rd;
					end
					count_q <= count_q - COUNT_W'(1);
				end
			end else if (do_add) begin
				member_q[idx_s1] <= 1'b1;
				newest_q         <= idx_s1;
				if (count_q == '0) begin
					oldest_q <= idx_s1;
				end
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	assign found        = found_q;
	assign victim_frame = vf_q;
	assign count        = count_q;

endmodule

[rtl/lru_frame_replacer.sv]
// ---------------------------------------------------------------------------
// lru_frame_replacer
// Keeps evictable frames in unpin order; serves pin, unpin and victim words.
// ---------------------------------------------------------------------------
// For each request word, the accept cycle reads the older and
// newer link RAMs at the addressed frame (the oldest frame for a victim
// request), and the next cycle writes the links back, updates the end
// pointers, member bits and count, and loads the response register. One
// request is in flight at a time; a new one is accepted as soon as the
// response register is empty or being taken. Frames at or above NUM_FRAMES
// are ignored by pin and unpin.
module lru_frame_replacer
	import lfr_pkg::*;
#(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lfr_req_if.sink   req,
	lfr_rsp_if.source rsp
);

	lfr_cmd_t cmd;

	lfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	lfr_dpath #(.NUM_FRAMES(NUM_FRAMES)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (req.action),
		.frame        (req.frame),
		.found        (rsp.found),
		.victim_frame (rsp.victim_frame),
		.count        (rsp.count)
	);

endmodule
